// ----- design/soft_mask_to_hard_mask_runs_core_assert.svh -----
// assertion macros shared by the core's checking code
`ifndef SOFT_MASK_TO_HARD_MASK_RUNS_CORE_ASSERT_SVH
`define SOFT_MASK_TO_HARD_MASK_RUNS_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SMHM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smhm same-cycle check failed");

// next-cycle implication, checked outside reset
`define SMHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smhm next-cycle check failed");

`endif

// ----- design/smhm_pkg.sv -----
// shared types, constants and helpers of the soft-mask to hard-mask core
package smhm_pkg;

   localparam int POS_BITS    = 32;
   localparam int OUT_BITS    = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] MASK_RESET = 8'h4E;

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [OUT_BITS-1:0] out_pos_type;
   typedef logic [QIDX_BITS:0]  qcount_type;
   typedef logic [QIDX_BITS-1:0] qidx_type;

   typedef enum logic [1:0] {
      PH_PRE  = 2'd0,
      PH_HEAD = 2'd1,
      PH_SEQ  = 2'd2
   } phase_type;

   // one queued action: optional run record, then optional byte
   typedef struct packed {
      logic        rec_valid;
      logic        byte_valid;
      logic [7:0]  data_byte;
      out_pos_type run_begin;
      out_pos_type run_end;
   } entry_type;

   function automatic out_pos_type clip_out(input pos_type v);
      logic [POS_BITS+OUT_BITS-1:0] wide;
      logic [POS_BITS+OUT_BITS-1:0] lim;
      wide = {{OUT_BITS{1'b0}}, v};
      lim  = {{POS_BITS{1'b0}}, {OUT_BITS{1'b1}}};
      if (wide > lim) return {OUT_BITS{1'b1}};
      return wide[OUT_BITS-1:0];
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

endpackage

// ----- design/smhm_front.sv -----
// front end: byte classification, parse state and position counter
module smhm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                end_of_stream,
   input  logic                csr_write_en,
   input  logic [7:0]          csr_mask_char,
   output logic                ent_push,
   output smhm_pkg::entry_type ent
);
   import smhm_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       in_run_ff, in_run_in;
   pos_type    position_ff, position_in;
   pos_type    run_start_ff, run_start_in;
   logic [7:0] mask_ff;
   pos_type    pos_inc;
   pos_type    begin_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PRE;
         in_run_ff    <= 1'b0;
         position_ff  <= '0;
         run_start_ff <= '0;
         mask_ff      <= MASK_RESET;
      end else begin
         phase_ff     <= phase_in;
         in_run_ff    <= in_run_in;
         position_ff  <= position_in;
         run_start_ff <= run_start_in;
         if (csr_write_en) begin
            mask_ff <= csr_mask_char;
         end
      end
   end

   // saturating count and 1-based run start
   assign pos_inc   = (position_ff == POS_MAX) ? POS_MAX : position_ff + pos_type'(1);
   assign begin_sat = (run_start_ff == POS_MAX) ? POS_MAX : run_start_ff + pos_type'(1);

   always_comb begin
      phase_in       = phase_ff;
      in_run_in      = in_run_ff;
      position_in    = position_ff;
      run_start_in   = run_start_ff;
      ent            = '0;
      ent.run_begin  = clip_out(begin_sat);
      ent.run_end    = clip_out(position_ff);
      if (accept) begin
         if (end_of_stream) begin
            ent.rec_valid = (phase_ff == PH_SEQ) && in_run_ff;
            phase_in      = PH_PRE;
            in_run_in     = 1'b0;
            position_in   = '0;
            run_start_in  = '0;
         end else begin
            unique case (phase_ff)
               PH_HEAD: begin
                  ent.byte_valid = 1'b1;
                  ent.data_byte  = in_byte;
                  if (in_byte == CHAR_LF) begin
                     phase_in = PH_SEQ;
                  end
               end
               PH_SEQ: begin
                  ent.byte_valid = 1'b1;
                  ent.data_byte  = in_byte;
                  if (in_byte == CHAR_GT) begin
                     ent.rec_valid = in_run_ff;
                     in_run_in     = 1'b0;
                     position_in   = '0;
                     phase_in      = PH_HEAD;
                  end else if (!is_space(in_byte)) begin
                     position_in = pos_inc;
                     if (in_run_ff) begin
                        if (is_upper(in_byte)) begin
                           in_run_in     = 1'b0;
                           ent.rec_valid = 1'b1;
                        end else begin
                           ent.data_byte = mask_ff;
                        end
                     end else if (is_lower(in_byte)) begin
                        in_run_in     = 1'b1;
                        run_start_in  = position_ff;
                        ent.data_byte = mask_ff;
                     end
                  end
               end
               default: begin
                  // before the first header, and the unused code
                  ent.byte_valid = 1'b1;
                  ent.data_byte  = in_byte;
                  phase_in       = (in_byte == CHAR_GT) ? PH_HEAD : PH_PRE;
               end
            endcase
         end
      end
      ent_push = accept && (ent.rec_valid || ent.byte_valid);
   end

endmodule

// ----- design/smhm_queue.sv -----
// small action queue between front and back end
module smhm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  smhm_pkg::entry_type push_ent,
   input  logic                pop,
   output smhm_pkg::entry_type head,
   output logic                q_full,
   output logic                q_empty
);
   import smhm_pkg::*;

   entry_type  mem_ff [QUEUE_DEPTH];
   qidx_type   wr_ptr_ff, wr_ptr_in;
   qidx_type   rd_ptr_ff, rd_ptr_in;
   qcount_type count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full  = (count_ff == qcount_type'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_push = push && !q_full;
   assign do_pop  = pop && !q_empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + qidx_type'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + qidx_type'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + qcount_type'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - qcount_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule

// ----- design/smhm_back.sv -----
// back end: turns one queued action into one or two results
module smhm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  smhm_pkg::entry_type     head,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic                    pop,
   output logic                    empty,
   output logic                    rsp_result_kind,
   output logic [7:0]              rsp_out_byte,
   output smhm_pkg::out_pos_type   rsp_run_begin,
   output smhm_pkg::out_pos_type   rsp_run_end,
   output logic                    rsp_last
);
   import smhm_pkg::*;

   logic rec_done_ff, rec_done_in;
   logic show_rec, taken;

   assign show_rec = head.rec_valid && !rec_done_ff;
   assign taken    = pop && !q_empty;
   assign empty    = q_empty;

   assign rsp_result_kind = show_rec;
   assign rsp_out_byte    = show_rec ? 8'h00 : head.data_byte;
   assign rsp_run_begin   = show_rec ? head.run_begin : '0;
   assign rsp_run_end     = show_rec ? head.run_end : '0;
   assign rsp_last        = show_rec ? !head.byte_valid : 1'b1;

   // a record with a byte behind it holds the entry; the byte half releases it
   always_comb begin
      q_pop       = taken && !(show_rec && head.byte_valid);
      rec_done_in = rec_done_ff;
      if (taken) begin
         rec_done_in = show_rec && head.byte_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_done_ff <= 1'b0;
      end else begin
         rec_done_ff <= rec_done_in;
      end
   end

endmodule

// ----- design/soft_mask_to_hard_mask_runs_core.sv -----
// top level of the fasta soft-mask to hard-mask converter with run reporting
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------
//   request  | req_in_byte, req_end_of_stream          | push / full
//   response | rsp_result_kind, rsp_out_byte,          | empty / pop
//            | rsp_run_begin, rsp_run_end, rsp_last    |
//   csr      | csr_mask_char                           | csr_write_en
//
// one byte is taken per cycle while the action queue (four entries) has room
// a byte that closes a run yields two responses, so it holds the back end for
// both; the queue registers each entry before its response can show
// end-of-stream outside sequence lines yields no response at all
// reset is synchronous and needs no clearing pass; mask_char returns to 'N'
// a stalled response side fills the queue, then full rises and stalls push
module soft_mask_to_hard_mask_runs_core (
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_end_of_stream,
   // response
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_result_kind,
   output logic [7:0]            rsp_out_byte,
   output smhm_pkg::out_pos_type rsp_run_begin,
   output smhm_pkg::out_pos_type rsp_run_end,
   output logic                  rsp_last,
   // csr
   input  logic                  csr_write_en,
   input  logic [7:0]            csr_mask_char
);
   import smhm_pkg::*;

   logic      accept;
   logic      ent_push;
   entry_type ent;
   entry_type head;
   logic      q_full, q_empty, q_pop;

   // request transaction when the queue can take the worst case of one entry
   assign full   = q_full;
   assign accept = push && !q_full;

   // classify the byte and update parse state, position and run start
   smhm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_stream (req_end_of_stream),
      .csr_write_en  (csr_write_en),
      .csr_mask_char (csr_mask_char),
      .ent_push      (ent_push),
      .ent           (ent)
   );

   // decouples front from back so each stalls on its own
   smhm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (ent_push),
      .push_ent (ent),
      .pop      (q_pop),
      .head     (head),
      .q_full   (q_full),
      .q_empty  (q_empty)
   );

   // record first, then the byte, each as its own response transaction
   smhm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_begin   (rsp_run_begin),
      .rsp_run_end     (rsp_run_end),
      .rsp_last        (rsp_last)
   );

`include "soft_mask_to_hard_mask_runs_core_assert.svh"

   // a run always covers at least its opening byte
   `SMHM_ASSERT_NOW(a_run_order, clock, reset, !empty && rsp_result_kind, rsp_run_begin <= rsp_run_end)
   // a record that is not last is followed by its byte
   `SMHM_ASSERT_NEXT(a_rec_then_byte, clock, reset, pop && !empty && rsp_result_kind && !rsp_last, !empty && !rsp_result_kind)
   // the front never writes into a full queue
   `SMHM_ASSERT_NOW(a_no_push_full, clock, reset, ent_push, !q_full)

endmodule

// ----- tb/soft_mask_to_hard_mask_runs_core_tb.sv -----
// self-checking testbench for the fasta soft-mask to hard-mask core with run records
module soft_mask_to_hard_mask_runs_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smhm_pkg::*;

   // clocking, reset and run limits
   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 8;
   localparam int IDLE_LIMIT     = 2000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int ITEM_TARGET    = 900;
   localparam int CFG_INTERVAL   = 150;

   // response kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   // character classes used by the prediction and the stimulus
   localparam logic [7:0] UC_FIRST   = 8'h41;
   localparam logic [7:0] UC_LAST    = 8'h5A;
   localparam logic [7:0] LC_FIRST   = 8'h61;
   localparam logic [7:0] LC_LAST    = 8'h7A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   typedef enum logic [1:0] {
      STALL_NONE    = 2'd0,
      STALL_RANDOM  = 2'd1,
      STALL_PATTERN = 2'd2
   } stall_style_type;

   // one expected response transaction
   typedef struct {
      logic        kind;
      logic [7:0]  data;
      out_pos_type run_first;
      out_pos_type run_final;
      logic        is_last;
   } hm_result_type;

   // dut ports, every input known from time zero
   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        push              = 1'b0;
   logic        full;
   logic [7:0]  req_in_byte       = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        empty;
   logic        pop               = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_out_byte;
   out_pos_type rsp_run_begin;
   out_pos_type rsp_run_end;
   logic        rsp_last;
   logic        csr_write_en      = 1'b0;
   logic [7:0]  csr_mask_char     = 8'h00;

   // predictor state: mirrors the converter's record phase, run and counters
   hm_result_type hardmask_out_q[$];
   phase_type  seq_phase  = PH_PRE;
   logic       run_open   = 1'b0;
   pos_type    byte_pos   = '0;
   pos_type    run_origin = '0;
   logic [7:0] mask_now   = MASK_RESET;

   // idling controls for sender and receiver
   stall_style_type stall_style = STALL_NONE;
   logic         gaps_on     = 1'b0;
   logic         holdoff_go  = 1'b0;
   int           burst_left  = 0;

   // bookkeeping
   int error_count       = 0;
   int items_sent        = 0;
   int responses_checked = 0;
   int records_checked   = 0;
   int mask_writes       = 0;
   int full_stall_cycles = 0;
   int idle_cycles       = 0;

   soft_mask_to_hard_mask_runs_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .empty             (empty),
      .pop               (pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_begin     (rsp_run_begin),
      .rsp_run_end       (rsp_run_end),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_mask_char     (csr_mask_char)
   );

   always #CLK_HALF clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // wide counters are clipped to the 32-bit response fields
   function automatic out_pos_type clip_pos(input pos_type v);
      longint unsigned w;
      w = 0;
      w = 64'(v);
      if (w > 64'hFFFF_FFFF) return '1;
      return w[OUT_BITS-1:0];
   endfunction

   function automatic hm_result_type byte_result(input logic [7:0] b);
      hm_result_type r;
      r.kind      = KIND_BYTE;
      r.data      = b;
      r.run_first = '0;
      r.run_final = '0;
      r.is_last   = 1'b0;
      return r;
   endfunction

   // interval of the open run, 1-based; start saturates with the counter
   function automatic hm_result_type run_record();
      hm_result_type r;
      r.kind      = KIND_RUN;
      r.data      = 8'h00;
      r.run_first = clip_pos((run_origin == POS_MAX) ? run_origin : run_origin + 1'b1);
      r.run_final = clip_pos(byte_pos);
      r.is_last   = 1'b0;
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // advance the converter by one accepted byte and queue what it emits
   function automatic void hard_mask_byte(input logic [7:0] c, input logic eos);
      hm_result_type outs[2];
      int         n;
      n = 0;
      if (eos) begin
         // end of stream: flush an open run, then back to the start
         if (seq_phase == PH_SEQ && run_open) begin
            outs[n] = run_record();
            n++;
         end
         seq_phase  = PH_PRE;
         run_open   = 1'b0;
         byte_pos   = '0;
         run_origin = '0;
      end else if (seq_phase == PH_HEAD) begin
         outs[n] = byte_result(c);
         n++;
         if (c == CHAR_LF) seq_phase = PH_SEQ;
      end else if (seq_phase == PH_SEQ) begin
         if (c == CHAR_GT) begin
            // next header closes the run, record before the echoed '>'
            if (run_open) begin
               outs[n] = run_record();
               n++;
            end
            outs[n] = byte_result(c);
            n++;
            run_open  = 1'b0;
            byte_pos  = '0;
            seq_phase = PH_HEAD;
         end else if (is_blank(c)) begin
            outs[n] = byte_result(c);
            n++;
         end else begin
            if (run_open) begin
               if (c >= UC_FIRST && c <= UC_LAST) begin
                  run_open = 1'b0;
                  outs[n] = run_record();
                  n++;
                  outs[n] = byte_result(c);
                  n++;
               end else begin
                  outs[n] = byte_result(mask_now);
                  n++;
               end
            end else if (c >= LC_FIRST && c <= LC_LAST) begin
               run_open   = 1'b1;
               run_origin = byte_pos;
               outs[n] = byte_result(mask_now);
               n++;
            end else begin
               outs[n] = byte_result(c);
               n++;
            end
            if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
         end
      end else begin
         // before the first header, and the unused phase code
         outs[n] = byte_result(c);
         n++;
         seq_phase = (c == CHAR_GT) ? PH_HEAD : PH_PRE;
      end
      if (n > 0) outs[n-1].is_last = 1'b1;
      for (int i = 0; i < n; i++) hardmask_out_q.push_back(outs[i]);
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // every accepted response transaction against the oldest pending one
   always @(posedge clock) begin : check_responses
      hm_result_type want;
      if (!reset && pop && !empty) begin
         if (hardmask_out_q.size() == 0) begin
            report_mismatch("unexpected response kind", rsp_result_kind, 0);
         end else begin
            want = hardmask_out_q.pop_front();
            responses_checked++;
            if (want.kind == KIND_RUN) records_checked++;
            if (rsp_result_kind != want.kind)
               report_mismatch("result kind", rsp_result_kind, want.kind);
            if (rsp_out_byte != want.data)
               report_mismatch("out byte", rsp_out_byte, want.data);
            if (rsp_run_begin != want.run_first)
               report_mismatch("run begin", rsp_run_begin, want.run_first);
            if (rsp_run_end != want.run_final)
               report_mismatch("run end", rsp_run_end, want.run_final);
            if (rsp_last != want.is_last)
               report_mismatch("last flag", rsp_last, want.is_last);
         end
      end
   end

   // watchdog: ends the run once nothing has moved for too long
   always @(posedge clock) begin
      if (push && full) full_stall_cycles++;
      if ((push && !full) || (pop && !empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d responses still pending",
                     $time, IDLE_LIMIT, hardmask_out_q.size());
            $display("soft_mask_to_hard_mask_runs_core_tb: done, errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // response side: pop pattern plus an occasional long hold-off
   // ------------------------------------------------------------------

   initial begin : drive_pop
      int rx_tick;
      rx_tick = 0;
      forever begin
         @(posedge clock);
         rx_tick++;
         if (holdoff_go) begin
            // long hold-off so the queue fills and full stalls the sender
            holdoff_go = 1'b0;
            pop <= 1'b0;
            for (int k = 1; k < HOLDOFF_CYCLES; k++) @(posedge clock);
         end else begin
            case (stall_style)
               STALL_RANDOM:  pop <= ($urandom_range(0, 99) >= 40);
               STALL_PATTERN: pop <= ((rx_tick % 13) >= 5);
               default:       pop <= 1'b1;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offer one byte and wait until it is taken, in bursts with random gaps if gaps_on
   task automatic send_item(input logic [7:0] b, input logic eos);
      if (gaps_on && burst_left == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      push              <= 1'b1;
      req_in_byte       <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (full) @(posedge clock);
      hard_mask_byte(b, eos);
      items_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // drain: every pending response back, then room for a silent end of stream
   task automatic wait_for_idle();
      push <= 1'b0;
      while (hardmask_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask_char(input logic [7:0] v);
      wait_for_idle();
      csr_mask_char <= v;
      csr_write_en  <= 1'b1;
      @(posedge clock);
      mask_now = v;
      mask_writes++;
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // hand-picked bytes: phases, class boundaries, run open/close, flushes
   task automatic test_directed_cases();
      // preamble bytes echoed, lowercase included, end of stream silent
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("a\n");
      send_item(8'h5A, 1'b1);
      // end of stream inside a header is silent too
      send_text(">h");
      send_item(8'h00, 1'b1);
      // a '>' inside a header is just echoed
      send_text(">q>\n");
      // non-letters around the letter ranges, then a run with blanks inside
      send_text("A@[`{a \t");
      send_item(CHAR_CR, 1'b0);
      send_item(8'h0B, 1'b0);
      send_item(8'h0C, 1'b0);
      send_item(8'h08, 1'b0);
      send_item(8'h0E, 1'b0);
      send_item(8'h80, 1'b0);
      // 'Z' closes, 'z'/'A' reopen and close, next header flushes a run
      send_text("zZzAg>\nc");
      // end of stream flushes the open run
      send_item(8'hFF, 1'b1);
      // end of stream in sequence with no run open
      send_text(">\nT");
      send_item(8'h00, 1'b1);
   endtask

   // mask register at its extremes, a random value and back to reset
   task automatic test_mask_register();
      logic [7:0] masks[4];
      masks[0] = 8'h00;
      masks[1] = 8'hFF;
      masks[2] = 8'($urandom_range(0, 255));
      masks[3] = MASK_RESET;
      foreach (masks[i]) begin
         write_mask_char(masks[i]);
         send_text(">m\nacGt");
         send_item(8'h00, 1'b1);
      end
   endtask

   // receiver held off while the sender keeps offering: queue fills, full rises
   task automatic test_queue_backpressure();
      stall_style = STALL_NONE;
      gaps_on     = 1'b0;
      send_text(">p\n");
      holdoff_go = 1'b1;
      send_text("aaaaCCCCggTTacgtACGTnnnnNNNN tt AAcc\ngT");
      send_item(8'h00, 1'b1);
   endtask

   // one well-formed record with random header and run-structured sequence
   task automatic send_fasta_record();
      int         head_len;
      int         seq_len;
      logic       lower;
      logic [7:0] b;
      send_item(CHAR_GT, 1'b0);
      head_len = $urandom_range(0, 12);
      repeat (head_len) begin
         b = 8'($urandom_range(0, 255));
         if (b == CHAR_LF) b = CHAR_TILDE;
         send_item(b, 1'b0);
      end
      send_item(CHAR_LF, 1'b0);
      // case flips now and then, so runs have lengths
      seq_len = $urandom_range(4, 70);
      lower   = 1'($urandom_range(0, 1));
      repeat (seq_len) begin
         if ($urandom_range(0, 4) == 0) lower = ~lower;
         case ($urandom_range(0, 19))
            0:       b = CHAR_LF;
            1:       b = ($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                                     : 8'($urandom_range(9, 13));
            2:       b = 8'($urandom_range(0, 255));
            default: b = lower ? 8'($urandom_range(LC_FIRST, LC_LAST))
                               : 8'($urandom_range(UC_FIRST, UC_LAST));
         endcase
         send_item(b, 1'b0);
      end
      if ($urandom_range(0, 5) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // mostly records, some noise; idling and mask change between stretches
   task automatic test_random_records();
      int next_cfg;
      next_cfg = items_sent + CFG_INTERVAL;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_cfg) begin
            case ($urandom_range(0, 3))
               0:       write_mask_char(8'h00);
               1:       write_mask_char(8'hFF);
               default: write_mask_char(8'($urandom_range(0, 255)));
            endcase
            next_cfg = items_sent + CFG_INTERVAL;
         end
         stall_style = stall_style_type'($urandom_range(0, 2));
         gaps_on     = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
         end else begin
            send_fasta_record();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_mask_register();
      test_queue_backpressure();
      test_random_records();

      stall_style = STALL_RANDOM;
      wait_for_idle();

      $display("covered %0d input bytes, %0d responses checked of which %0d run records",
               items_sent, responses_checked, records_checked);
      $display("mask written %0d times, input held off by full for %0d cycles",
               mask_writes, full_stall_cycles);
      if (error_count == 0) begin
         $display("soft_mask_to_hard_mask_runs_core_tb: done, clean");
      end else begin
         $display("soft_mask_to_hard_mask_runs_core_tb: done, errors");
      end
      $finish;
   end

endmodule
